@@ hw/rtl/nusc_pkg.sv @@
// Shared types, codes and constants for the Annex B NAL unit splitter/classifier.
// No dependencies; imported by every module of the block.
package nusc_pkg;

    // Widths fixed by the beat fields and the frame counter
    localparam int FRAME_BITS = 23;
    localparam int OUT_BITS   = 22;

    localparam logic [OUT_BITS-1:0]   OUT_MAX         = 22'h3f_ffff;
    localparam logic [FRAME_BITS-1:0] MAX_FRAME_RESET = 23'h40_0000;
    localparam logic [FRAME_BITS-1:0] DELIM_BYTES     = 23'd4;
    localparam logic [7:0]            START_CODE_LAST = 8'h01;

    // NAL types that mark parameter sets
    localparam logic [5:0] H264_SPS = 6'd7;
    localparam logic [5:0] H264_PPS = 6'd8;
    localparam logic [5:0] HEVC_VPS = 6'd32;
    localparam logic [5:0] HEVC_SPS = 6'd33;
    localparam logic [5:0] HEVC_PPS = 6'd34;

    // Register index of max_frame_bytes (address bit 2)
    localparam logic REG_MAX_FRAME = 1'b0;

    typedef enum logic [1:0] {
        CMD_DATA      = 2'd0,
        CMD_EOS       = 2'd1,
        CMD_LINK_UP   = 2'd2,
        CMD_LINK_DOWN = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        FMT_UNKNOWN = 2'd0,
        FMT_H264    = 2'd1,
        FMT_HEVC    = 2'd2
    } fmt_t;

    typedef enum logic [1:0] {
        LINK_DOWN = 2'd0,
        LINK_WAIT = 2'd2,
        LINK_UP   = 2'd3
    } link_t;

    typedef enum logic [2:0] {
        ACT_MALFORMED = 3'd0,
        ACT_UNKNOWN   = 3'd1,
        ACT_GATED     = 3'd2,
        ACT_PARAM_SET = 3'd3,
        ACT_FRAME     = 3'd4,
        ACT_OVERFLOW  = 3'd5
    } action_t;

    // Input beat
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data_byte;
    } in_beat_t;

    // Result beat
    typedef struct packed {
        logic [5:0]          unit_type;
        logic [OUT_BITS-1:0] unit_length;
        fmt_t                stream_kind;
        action_t             action;
        logic [OUT_BITS-1:0] frame_length;
    } res_beat_t;

    // Stream/link/frame state touched by unit classification
    typedef struct packed {
        fmt_t                  stream_format;
        logic [5:0]            boundary_type;
        link_t                 link_state;
        logic [FRAME_BITS-1:0] frame_bytes;
    } cls_state_t;

    function automatic logic is_h264_ps(input logic [5:0] t);
        return (t == H264_SPS) || (t == H264_PPS);
    endfunction

    function automatic logic is_hevc_ps(input logic [5:0] t);
        return (t == HEVC_VPS) || (t == HEVC_SPS) || (t == HEVC_PPS);
    endfunction

endpackage

@@ hw/rtl/nusc_apb_regs.sv @@
// APB register file: holds max_frame_bytes.
// Depends on nusc_pkg.
module nusc_apb_regs
    import nusc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [FRAME_BITS-1:0] max_frame_bytes
);

    logic [FRAME_BITS-1:0] max_frame_reg;
    logic                  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_MAX_FRAME);

    // Capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_frame_reg <= MAX_FRAME_RESET;
        end else if (wr_en) begin
            max_frame_reg <= pwdata[FRAME_BITS-1:0];
        end
    end

    // Read mux
    assign prdata = (paddr[2] == REG_MAX_FRAME) ? {{(32-FRAME_BITS){1'b0}}, max_frame_reg}
                                                : 32'd0;

    assign max_frame_bytes = max_frame_reg;

endmodule

@@ hw/rtl/nusc_classify.sv @@
// Classifies one completed NAL unit: malformed check, format detection, gate,
// frame accounting and overflow. Pure combinational; depends on nusc_pkg.
module nusc_classify
    import nusc_pkg::*;
#(
    parameter int LENGTH_BITS = 23
) (
    input  logic [LENGTH_BITS-1:0] unit_len,
    input  logic [7:0]             header_byte,
    input  cls_state_t             cur_state,
    input  logic [FRAME_BITS-1:0]  max_frame_bytes,
    output cls_state_t             upd_state,
    output res_beat_t              result
);

    // Sum width covers frame + unit + delimiter without wrap
    localparam int SW = ((LENGTH_BITS > FRAME_BITS) ? LENGTH_BITS : FRAME_BITS) + 2;

    logic [SW-1:0]         len_ext;
    logic [SW-1:0]         sum;
    logic [5:0]            t5;
    logic [5:0]            t6;
    logic [5:0]            utype;
    action_t               act;
    logic [FRAME_BITS-1:0] fb_new;
    logic [OUT_BITS-1:0]   flen;
    logic                  done;
    logic                  ps;

    assign len_ext = SW'(unit_len);
    assign sum     = SW'(cur_state.frame_bytes) + len_ext + SW'(DELIM_BYTES);
    assign t5      = {1'b0, header_byte[4:0]};
    assign t6      = header_byte[6:1];

    always_comb begin
        upd_state = cur_state;
        utype     = '0;
        act       = ACT_MALFORMED;
        flen      = '0;
        fb_new    = '0;
        ps        = 1'b0;
        done      = 1'b0;

        // Too short or forbidden bit set
        if ((len_ext < SW'(2)) || header_byte[7]) begin
            done = 1'b1;
        end

        // Type extraction, format detection on first parameter set
        if (!done) begin
            case (cur_state.stream_format)
                FMT_H264: utype = t5;
                FMT_HEVC: utype = t6;
                default: begin
                    if (is_hevc_ps(t6)) begin
                        utype                   = t6;
                        upd_state.boundary_type = t6;
                        upd_state.stream_format = FMT_HEVC;
                    end else if (is_h264_ps(t5)) begin
                        utype                   = t5;
                        upd_state.boundary_type = t5;
                        upd_state.stream_format = FMT_H264;
                    end else begin
                        act  = ACT_UNKNOWN;
                        done = 1'b1;
                    end
                end
            endcase
        end

        // Link gate
        if (!done) begin
            if (cur_state.link_state != LINK_WAIT && cur_state.link_state != LINK_UP) begin
                act  = ACT_GATED;
                done = 1'b1;
            end else if (cur_state.link_state == LINK_WAIT) begin
                if (utype != upd_state.boundary_type) begin
                    act  = ACT_GATED;
                    done = 1'b1;
                end else begin
                    upd_state.link_state = LINK_UP;
                end
            end
        end

        // Frame accounting
        if (!done) begin
            if (sum >= SW'(max_frame_bytes)) begin
                act                   = ACT_OVERFLOW;
                upd_state.link_state  = LINK_DOWN;
                upd_state.frame_bytes = '0;
            end else begin
                // Unit length below capacity here, so its low frame bits are exact
                fb_new = cur_state.frame_bytes + len_ext[FRAME_BITS-1:0]
                       + ((cur_state.frame_bytes != '0) ? DELIM_BYTES : '0);
                ps = (upd_state.stream_format == FMT_HEVC) ? is_hevc_ps(utype)
                                                           : is_h264_ps(utype);
                if (ps) begin
                    act                   = ACT_PARAM_SET;
                    upd_state.frame_bytes = fb_new;
                end else begin
                    act                   = ACT_FRAME;
                    flen                  = (fb_new > FRAME_BITS'(OUT_MAX)) ? OUT_MAX
                                                                 : fb_new[OUT_BITS-1:0];
                    upd_state.frame_bytes = '0;
                end
            end
        end
    end

    // Descriptor
    always_comb begin
        result.unit_type    = utype;
        result.unit_length  = (len_ext > SW'(OUT_MAX)) ? OUT_MAX : len_ext[OUT_BITS-1:0];
        result.stream_kind  = upd_state.stream_format;
        result.action       = act;
        result.frame_length = flen;
    end

endmodule

@@ hw/rtl/nusc_out_buf.sv @@
// Result output register with a skid stage; ready toward the parser is registered.
// Depends on nusc_pkg.
module nusc_out_buf
    import nusc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  res_beat_t in_data,
    output logic      in_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output res_beat_t m_data
);

    logic      out_valid_reg;
    res_beat_t out_data_reg;
    logic      skid_valid_reg;
    res_beat_t skid_data_reg;
    logic      push;
    logic      pop;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && in_ready;
    assign pop      = out_valid_reg && m_ready;

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || pop) begin
            out_valid_reg <= push;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (!out_valid_reg || pop) begin
            if (push) begin
                out_data_reg <= in_data;
            end
        end else if (push) begin
            skid_data_reg <= in_data;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

@@ hw/rtl/nal_unit_splitter_classifier.sv @@
// Top level: byte scanner for start codes, unit classifier, result buffer, APB regs.
// Depends on nusc_pkg, nusc_apb_regs, nusc_classify, nusc_out_buf.
//
// Takes one stream byte or command beat per clock unless the result buffer is full,
// and produces at most one unit descriptor per beat, so throughput is one beat per
// cycle while the buffer has room. A beat is accepted into the scanner state in the
// cycle it arrives; its descriptor is registered in the output buffer. A two-entry
// output buffer (register plus skid) lets input keep flowing while the result side
// stalls; input stops only once both entries hold results. The start code 00 00 00
// 01 is matched only when its zero bytes all follow the previous start code. Unit
// lengths count with LENGTH_BITS bits and saturate there.
module nal_unit_splitter_classifier
    import nusc_pkg::*;
#(
    parameter int LENGTH_BITS = 23
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_beat_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output res_beat_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

    logic [23:0]            tail_reg, tail_next;
    logic                   synced_reg, synced_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic [7:0]             header_reg, header_next;
    cls_state_t             cls_reg, cls_next;

    logic [FRAME_BITS-1:0]  max_frame_bytes;
    logic                   accept;
    logic                   start_hit;
    logic                   close_fire;
    logic [LENGTH_BITS-1:0] close_len;
    cls_state_t             cls_upd;
    res_beat_t              cls_result;
    logic                   buf_ready;

    // Configuration
    nusc_apb_regs u_regs (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .max_frame_bytes (max_frame_bytes)
    );

    assign s_ready = buf_ready;
    assign accept  = s_valid && s_ready;

    // Start code: 01 after three zero bytes inside the current unit
    assign start_hit = (s_data.data_byte == START_CODE_LAST) && (tail_reg == '0)
                    && (count_reg >= LENGTH_BITS'(3));
    assign close_fire = accept && synced_reg
                     && ((s_data.cmd == CMD_EOS) || ((s_data.cmd == CMD_DATA) && start_hit));
    assign close_len  = (s_data.cmd == CMD_EOS) ? count_reg : count_reg - LENGTH_BITS'(3);

    nusc_classify #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_classify (
        .unit_len        (close_len),
        .header_byte     (header_reg),
        .cur_state       (cls_reg),
        .max_frame_bytes (max_frame_bytes),
        .upd_state       (cls_upd),
        .result          (cls_result)
    );

    // Scanner next state
    always_comb begin
        tail_next   = tail_reg;
        synced_next = synced_reg;
        count_next  = count_reg;
        header_next = header_reg;
        cls_next    = cls_reg;
        if (accept) begin
            unique case (s_data.cmd)
                CMD_LINK_UP: begin
                    cls_next.link_state  = LINK_WAIT;
                    cls_next.frame_bytes = '0;
                end
                CMD_LINK_DOWN: begin
                    cls_next.link_state  = LINK_DOWN;
                    cls_next.frame_bytes = '0;
                end
                CMD_EOS: begin
                    if (synced_reg) begin
                        cls_next = cls_upd;
                    end
                    synced_next = 1'b0;
                    count_next  = '0;
                    tail_next   = '0;
                end
                CMD_DATA: begin
                    if (start_hit) begin
                        if (synced_reg) begin
                            cls_next = cls_upd;
                        end
                        synced_next = 1'b1;
                        count_next  = '0;
                        tail_next   = '0;
                    end else begin
                        if (synced_reg && (count_reg == '0)) begin
                            header_next = s_data.data_byte;
                        end
                        if (count_reg != COUNT_MAX) begin
                            count_next = count_reg + LENGTH_BITS'(1);
                        end
                        tail_next = {tail_reg[15:0], s_data.data_byte};
                    end
                end
            endcase
        end
    end

    // Scanner and stream state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tail_reg   <= '0;
            synced_reg <= 1'b0;
            count_reg  <= '0;
            header_reg <= '0;
            cls_reg    <= '{stream_format: FMT_UNKNOWN, boundary_type: '0,
                            link_state: LINK_DOWN, frame_bytes: '0};
        end else begin
            tail_reg   <= tail_next;
            synced_reg <= synced_next;
            count_reg  <= count_next;
            header_reg <= header_next;
            cls_reg    <= cls_next;
        end
    end

    // Result buffer
    nusc_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (close_fire),
        .in_data  (cls_result),
        .in_ready (buf_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

`ifndef SYNTH
    // Link up always reopens the gate wait with an empty frame
    a_link_up: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_data.cmd == CMD_LINK_UP)
        |=> (cls_reg.link_state == LINK_WAIT) && (cls_reg.frame_bytes == '0))
        else $error("link up did not enter wait state");

    // End of stream drops sync and clears the unit count
    a_eos_unsync: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_data.cmd == CMD_EOS) |=> !synced_reg && (count_reg == '0))
        else $error("end of stream left parser synced");

    // The gate opens only once the stream format is known
    a_up_has_fmt: assert property (@(posedge aclk) disable iff (!aresetn)
        (cls_reg.link_state == LINK_UP) |-> (cls_reg.stream_format != FMT_UNKNOWN))
        else $error("link up with unknown stream format");

    // A completed frame holds at least one well-formed unit
    a_frame_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.action == ACT_FRAME) |-> (m_data.frame_length >= 22'd2))
        else $error("completed frame shorter than one unit");

    // Frame length is reported only for completed frames
    a_flen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.action != ACT_FRAME) |-> (m_data.frame_length == '0))
        else $error("frame length set on non-frame result");
`endif

endmodule

@@ verif/nusc_stream_checker.sv @@
// Checker for the NAL unit splitter: tracks stream, link and frame state from the
// accepted input beats and config writes, and compares each result beat in order.
// Depends on nusc_pkg for the beat types and the code names.
module nusc_stream_checker
    import nusc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_beat_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  res_beat_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          pending,
    output int          fail_count
);

    // Own copy of the block's state
    logic [FRAME_BITS-1:0] cap;
    logic [23:0]           tail;
    logic                  in_unit;
    logic [22:0]           nbytes;
    logic [7:0]            hdr;
    fmt_t                  fmt;
    logic [5:0]            gate_type;
    link_t                 link;
    int unsigned           frame_acc;

    res_beat_t descriptors_due[$];

    function automatic logic [OUT_BITS-1:0] clip_len(input int unsigned v);
        return (v > OUT_MAX) ? OUT_MAX : v[OUT_BITS-1:0];
    endfunction

    function automatic logic hevc_ps_type(input logic [5:0] t);
        return (t == HEVC_VPS) || (t == HEVC_SPS) || (t == HEVC_PPS);
    endfunction

    function automatic logic avc_ps_type(input logic [5:0] t);
        return (t == H264_SPS) || (t == H264_PPS);
    endfunction

    // Classify a finished unit; updates format, gate and frame state as the block does
    function automatic res_beat_t classify_unit(input int unsigned len);
        res_beat_t   r;
        action_t     act;
        logic [5:0]  t;
        logic        known;
        logic        ps;
        int unsigned flen;
        act   = ACT_MALFORMED;
        t     = '0;
        flen  = 0;
        known = 1'b0;
        if (len >= 2 && !hdr[7]) begin
            known = 1'b1;
            if (fmt == FMT_H264) begin
                t = {1'b0, hdr[4:0]};
            end else if (fmt == FMT_HEVC) begin
                t = hdr[6:1];
            end else if (hevc_ps_type(hdr[6:1])) begin
                // first parameter set fixes the format and the boundary type
                t = hdr[6:1];
                fmt = FMT_HEVC;
                gate_type = t;
            end else if (avc_ps_type({1'b0, hdr[4:0]})) begin
                t = {1'b0, hdr[4:0]};
                fmt = FMT_H264;
                gate_type = t;
            end else begin
                act   = ACT_UNKNOWN;
                known = 1'b0;
            end
        end
        if (known) begin
            if (link == LINK_DOWN || (link == LINK_WAIT && t != gate_type)) begin
                act = ACT_GATED;
            end else begin
                link = LINK_UP;
                if (frame_acc + len + 4 >= {9'b0, cap}) begin
                    act       = ACT_OVERFLOW;
                    link      = LINK_DOWN;
                    frame_acc = 0;
                end else begin
                    if (frame_acc > 0)
                        frame_acc += 4;
                    frame_acc += len;
                    ps = (fmt == FMT_HEVC) ? hevc_ps_type(t) : avc_ps_type(t);
                    if (ps) begin
                        act = ACT_PARAM_SET;
                    end else begin
                        act       = ACT_FRAME;
                        flen      = frame_acc;
                        frame_acc = 0;
                    end
                end
            end
        end
        r              = '0;
        r.unit_type    = known ? t : 6'd0;
        r.unit_length  = clip_len(len);
        r.stream_kind  = fmt;
        r.action       = act;
        r.frame_length = clip_len(flen);
        return r;
    endfunction

    // Advance the scanner by one input beat
    task automatic take_beat(input in_beat_t b);
        int unsigned n;
        n = nbytes;
        case (b.cmd)
            CMD_LINK_UP: begin
                link = LINK_WAIT;
                frame_acc = 0;
            end
            CMD_LINK_DOWN: begin
                link = LINK_DOWN;
                frame_acc = 0;
            end
            CMD_EOS: begin
                if (in_unit)
                    descriptors_due.push_back(classify_unit(n));
                in_unit = 1'b0;
                nbytes  = '0;
                tail    = '0;
            end
            default: begin
                if (b.data_byte == START_CODE_LAST && tail == '0 && nbytes >= 3) begin
                    if (in_unit)
                        descriptors_due.push_back(classify_unit(n - 3));
                    in_unit = 1'b1;
                    nbytes  = '0;
                    tail    = '0;
                end else begin
                    if (in_unit && nbytes == '0)
                        hdr = b.data_byte;
                    if (nbytes != '1)
                        nbytes++;
                    tail = {tail[15:0], b.data_byte};
                end
            end
        endcase
    endtask

    task automatic flag(input string what, input res_beat_t want, input res_beat_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t %s: expected type %0d len %0d kind %0d act %0d frame %0d, got type %0d len %0d kind %0d act %0d frame %0d",
                     $time, what, want.unit_type, want.unit_length, want.stream_kind,
                     want.action, want.frame_length, got.unit_type, got.unit_length,
                     got.stream_kind, got.action, got.frame_length);
    endtask

    always @(posedge aclk) begin
        res_beat_t want;
        if (!aresetn) begin
            cap        = MAX_FRAME_RESET;
            tail       = '0;
            in_unit    = 1'b0;
            nbytes     = '0;
            hdr        = '0;
            fmt        = FMT_UNKNOWN;
            gate_type  = '0;
            link       = LINK_DOWN;
            frame_acc  = 0;
            fail_count = 0;
            descriptors_due.delete();
        end else begin
            // register write
            if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_FRAME)
                cap = pwdata[FRAME_BITS-1:0];
            // input beat first; a same-edge result always belongs to an earlier beat
            if (s_valid && s_ready)
                take_beat(s_data);
            // result beat
            if (m_valid && m_ready) begin
                if (descriptors_due.size() == 0) begin
                    flag("result with none due", '0, m_data);
                end else begin
                    want = descriptors_due.pop_front();
                    if (m_data.unit_type !== want.unit_type ||
                        m_data.unit_length !== want.unit_length ||
                        m_data.stream_kind !== want.stream_kind ||
                        m_data.action !== want.action ||
                        m_data.frame_length !== want.frame_length)
                        flag("descriptor mismatch", want, m_data);
                end
            end
        end
        pending <= descriptors_due.size();
    end

endmodule

@@ verif/nal_unit_splitter_classifier_tb.sv @@
// Testbench top for nal_unit_splitter_classifier: drives Annex B byte streams, link
// commands and frame-size settings, and reports the checker's verdict.
// Depends on nusc_pkg, nal_unit_splitter_classifier and nusc_stream_checker.
module nal_unit_splitter_classifier_tb;
    import nusc_pkg::*;

    localparam int PHASE_BEATS   = 200;
    localparam int SETTLE_CYCLES = 4;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_beat_t    s_data;
    logic        m_valid;
    logic        m_ready = 1'b0;
    res_beat_t   m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int pending;
    int fail_count;
    int src_idle   = 0;
    int snk_stall  = 0;
    int beats_sent = 0;
    int src_idle_pct  [4] = '{0, 50, 0, 21};
    int snk_stall_pct [4] = '{0, 0, 50, 21};
    logic [31:0] frame_caps [4];

    // stream flavor and gate-opening type for this run
    bit         hevc;
    logic [5:0] gate_type;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    nal_unit_splitter_classifier dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    nusc_stream_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // Result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= snk_stall);
    end

    // One input beat; valid stays up after acceptance unless the next beat idles.
    // Ready only moves at rising edges, so it is looked at mid-cycle.
    task automatic put_beat(input cmd_t c, input logic [7:0] b);
        in_beat_t beat;
        beat.cmd       = c;
        beat.data_byte = b;
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(negedge aclk);
        while (!s_ready)
            @(negedge aclk);
        @(posedge aclk);
        beats_sent++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        put_beat(CMD_DATA, b);
    endtask

    task automatic put_start_code();
        put_byte(8'h00);
        put_byte(8'h00);
        put_byte(8'h00);
        put_byte(START_CODE_LAST);
    endtask

    function automatic logic [7:0] payload_byte();
        return ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
    endfunction

    // Start code, NAL header for the run's flavor, then body bytes
    task automatic put_unit(input logic [5:0] t, input logic forbidden, input int body);
        put_start_code();
        if (hevc) begin
            put_byte({forbidden, t, 1'b0});
            put_byte(8'($urandom_range(255)));
        end else begin
            put_byte({forbidden, 2'($urandom_range(3)), t[4:0]});
        end
        repeat (body)
            put_byte(payload_byte());
    endtask

    function automatic logic [5:0] pick_type();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return gate_type;
        if (r < 50)
            return hevc ? 6'(HEVC_VPS + $urandom_range(2)) : 6'(H264_SPS + $urandom_range(1));
        return hevc ? 6'($urandom_range(63)) : 6'($urandom_range(31));
    endfunction

    // Wait until every due descriptor is out and the pipeline has gone quiet
    task automatic settle();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (pending != 0);
        repeat (SETTLE_CYCLES)
            @(posedge aclk);
    endtask

    task automatic reg_write(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MAX_FRAME, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly well-formed units, with link events, stream ends, runts and noise
    task automatic random_step();
        int r;
        int body;
        r = $urandom_range(99);
        if (r < 72) begin
            body = ($urandom_range(99) < 85) ? $urandom_range(12) : $urandom_range(80, 13);
            put_unit(pick_type(), $urandom_range(9) == 0, body);
        end else if (r < 78) begin
            put_start_code();
            if ($urandom_range(1))
                put_byte(8'($urandom_range(255)));
        end else if (r < 85) begin
            put_beat(CMD_LINK_UP, 8'($urandom_range(255)));
        end else if (r < 88) begin
            put_beat(CMD_LINK_DOWN, 8'($urandom_range(255)));
        end else if (r < 92) begin
            put_beat(CMD_EOS, 8'($urandom_range(255)));
        end else if (r < 96) begin
            repeat ($urandom_range(4, 1))
                put_byte(payload_byte());
        end else begin
            // odd start codes: too few zeros, or one extra leading zero
            put_byte(8'h00);
            put_byte(8'h00);
            if ($urandom_range(1)) begin
                put_byte(8'h00);
                put_byte(8'h00);
            end
            put_byte(START_CODE_LAST);
        end
    endtask

    initial begin
        int start;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        hevc = $urandom_range(1);
        gate_type = hevc ? 6'(HEVC_VPS + $urandom_range(2)) : 6'(H264_SPS + $urandom_range(1));
        frame_caps[0] = 32'd64;
        frame_caps[1] = 32'd16;
        frame_caps[2] = $urandom_range(600, 100);
        frame_caps[3] = 32'd4194304;
        repeat (10)
            @(posedge aclk);
        aresetn <= 1'b1;

        // directed: junk before sync, back-to-back start codes, malformed and
        // unknown-format units, first parameter set, stream end and link drop
        put_byte(8'hff);
        put_byte(8'h00);
        put_beat(CMD_LINK_UP, 8'h00);
        put_start_code();
        put_start_code();
        put_byte(8'h80);
        put_byte(8'haa);
        put_start_code();
        put_byte(8'h65);
        put_byte(8'h11);
        put_start_code();
        if (hevc) begin
            put_byte({1'b0, gate_type, 1'b0});
            put_byte(8'h01);
        end else begin
            put_byte({3'b011, gate_type[4:0]});
            put_byte(8'h42);
        end
        put_beat(CMD_EOS, 8'hff);
        put_beat(CMD_EOS, 8'h00);
        put_beat(CMD_LINK_DOWN, 8'h5a);

        // random phases, each with its own idling pattern and frame capacity
        for (int p = 0; p < 4; p++) begin
            settle();
            src_idle  = src_idle_pct[p];
            snk_stall = snk_stall_pct[p];
            reg_write(frame_caps[p]);
            put_beat(CMD_LINK_UP, 8'($urandom_range(255)));
            start = beats_sent;
            while (beats_sent - start < PHASE_BEATS)
                random_step();
        end
        settle();

        if (fail_count == 0)
            $display("nal_unit_splitter_classifier_tb OK");
        else
            $display("nal_unit_splitter_classifier_tb NOT OK");
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("nal_unit_splitter_classifier_tb NOT OK");
        $finish;
    end

endmodule
